[src/rrsg_pkg.sv]
// ----------------------------------------------------------------------------
// rrsg_pkg
// Shared types, sizes and codes for the round-robin single-grant scheduler.
// ----------------------------------------------------------------------------
package rrsg_pkg;

    localparam int SLOTS    = 6;
    localparam int SLOT_W   = 3;
    localparam int CUR_W    = $clog2(SLOTS);
    localparam int OP_W     = 3;
    localparam int BLK_W    = 24;
    localparam int TIME_W   = 32;
    localparam int COOL_W   = 16;
    localparam int FAIL_W   = 8;
    localparam int REF_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [BLK_W-1:0]  MIN_FREE_RST  = BLK_W'(10240);
    localparam logic [COOL_W-1:0] COOLDOWN_RST  = COOL_W'(500);
    localparam logic [FAIL_W-1:0] FAIL_LIMIT_RST = FAIL_W'(36);
    localparam logic [FAIL_W-1:0] FAIL_MAX      = '1;

    localparam logic [OP_W-1:0] OP_START   = OP_W'(0);
    localparam logic [OP_W-1:0] OP_DONE    = OP_W'(1);
    localparam logic [OP_W-1:0] OP_ADVANCE = OP_W'(2);
    localparam logic [OP_W-1:0] OP_SUCCESS = OP_W'(3);
    localparam logic [OP_W-1:0] OP_FAILURE = OP_W'(4);

    localparam logic [REF_W-1:0] REF_GRANTED  = REF_W'(0);
    localparam logic [REF_W-1:0] REF_BUSY     = REF_W'(1);
    localparam logic [REF_W-1:0] REF_NOT_TURN = REF_W'(2);
    localparam logic [REF_W-1:0] REF_LOW_HEAP = REF_W'(3);
    localparam logic [REF_W-1:0] REF_COOLDOWN = REF_W'(4);
    localparam logic [REF_W-1:0] REF_NO_REQ   = REF_W'(5);

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_LIMIT = CFG_IDX_W'(2);

    typedef logic [SLOTS-1:0] t_slots;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [SLOT_W-1:0] slot;
        logic [SLOTS-1:0]  due_mask;
        logic [BLK_W-1:0]  free_block;
        logic [TIME_W-1:0] now_ms;
    } t_item;

    typedef struct packed {
        logic [BLK_W-1:0]  min_free_block;
        logic [COOL_W-1:0] cooldown_length;
        logic [FAIL_W-1:0] fail_limit;
    } t_cfg;

    typedef struct packed {
        logic              granted;
        logic [REF_W-1:0]  refusal;
        logic [CUR_W-1:0]  cursor;
        logic              busy_res;
        logic              restart_request;
    } t_result;

endpackage

[src/rrsg_in_if.sv]
// ----------------------------------------------------------------------------
// rrsg_in_if
// Request channel: valid/ready handshake with one scheduler item.
// ----------------------------------------------------------------------------
interface rrsg_in_if;
    logic                        valid;
    logic                        ready;
    logic [rrsg_pkg::OP_W-1:0]   opcode;
    logic [rrsg_pkg::SLOT_W-1:0] slot;
    logic [rrsg_pkg::SLOTS-1:0]  due_mask;
    logic [rrsg_pkg::BLK_W-1:0]  free_block;
    logic [rrsg_pkg::TIME_W-1:0] now_ms;

    modport source (output valid, opcode, slot, due_mask, free_block, now_ms,
                    input ready);
    modport sink   (input valid, opcode, slot, due_mask, free_block, now_ms,
                    output ready);
endinterface

[src/rrsg_out_if.sv]
// ----------------------------------------------------------------------------
// rrsg_out_if
// Result channel: valid/ready handshake with one scheduler result.
// ----------------------------------------------------------------------------
interface rrsg_out_if;
    logic                        valid;
    logic                        ready;
    logic                        granted;
    logic [rrsg_pkg::REF_W-1:0]  refusal;
    logic [rrsg_pkg::CUR_W-1:0]  cursor;
    logic                        busy_res;
    logic                        restart_request;

    modport source (output valid, granted, refusal, cursor, busy_res,
                    restart_request, input ready);
    modport sink   (input valid, granted, refusal, cursor, busy_res,
                    restart_request, output ready);
endinterface

[src/rrsg_cfg_regs.sv]
// ----------------------------------------------------------------------------
// rrsg_cfg_regs
// Configuration registers: heap threshold, cooldown length, failure limit.
// ----------------------------------------------------------------------------
module rrsg_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rrsg_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rrsg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output rrsg_pkg::t_cfg                     o_cfg
);

    rrsg_pkg::t_cfg r_cfg;
    rrsg_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rrsg_pkg::CFG_MIN_FREE: begin
                    n_cfg.min_free_block = i_cfg_data[rrsg_pkg::BLK_W-1:0];
                end
                rrsg_pkg::CFG_COOLDOWN: begin
                    n_cfg.cooldown_length = i_cfg_data[rrsg_pkg::COOL_W-1:0];
                end
                rrsg_pkg::CFG_FAIL_LIMIT: begin
                    n_cfg.fail_limit = i_cfg_data[rrsg_pkg::FAIL_W-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_free_block  <= rrsg_pkg::MIN_FREE_RST;
            r_cfg.cooldown_length <= rrsg_pkg::COOLDOWN_RST;
            r_cfg.fail_limit      <= rrsg_pkg::FAIL_LIMIT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[src/rrsg_sched.sv]
// ----------------------------------------------------------------------------
// rrsg_sched
// Scheduler state and single-pass next-state / result logic per transaction.
// ----------------------------------------------------------------------------
module rrsg_sched (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  rrsg_pkg::t_item      i_item,
    input  rrsg_pkg::t_cfg       i_cfg,
    output rrsg_pkg::t_result    o_res
);

    localparam int IDX_W = rrsg_pkg::CUR_W + 1;

    rrsg_pkg::t_slots                  r_grant_flags;
    rrsg_pkg::t_slots                  n_grant_flags;
    logic [rrsg_pkg::CUR_W-1:0]        r_cursor;
    logic [rrsg_pkg::CUR_W-1:0]        n_cursor;
    logic [rrsg_pkg::TIME_W-1:0]       r_cool_until;
    logic [rrsg_pkg::TIME_W-1:0]       n_cool_until;
    logic [rrsg_pkg::FAIL_W-1:0]       r_fail_count;
    logic [rrsg_pkg::FAIL_W-1:0]       n_fail_count;

    logic                              slot_ok;
    rrsg_pkg::t_slots                  slot_bit;
    logic                              held;
    logic                              busy;
    logic                              low_heap;
    logic                              cooling;
    logic [rrsg_pkg::CUR_W-1:0]        done_cursor;
    logic [rrsg_pkg::CUR_W-1:0]        adv_cursor;
    logic                              found;
    logic [IDX_W-1:0]                  idx;
    logic [rrsg_pkg::FAIL_W-1:0]       fail_inc;

    assign slot_ok  = i_item.slot < rrsg_pkg::SLOT_W'(rrsg_pkg::SLOTS);
    assign slot_bit = slot_ok ? (rrsg_pkg::t_slots'(1) << i_item.slot) : '0;
    assign held     = (r_grant_flags & slot_bit) != '0;
    assign busy     = r_grant_flags != '0;
    assign low_heap = i_item.free_block < i_cfg.min_free_block;
    assign cooling  = i_item.now_ms < r_cool_until;
    assign fail_inc = (r_fail_count != rrsg_pkg::FAIL_MAX) ?
                      r_fail_count + rrsg_pkg::FAIL_W'(1) : r_fail_count;

    assign done_cursor =
        (i_item.slot == rrsg_pkg::SLOT_W'(rrsg_pkg::SLOTS - 1)) ?
        '0 : rrsg_pkg::CUR_W'(i_item.slot + rrsg_pkg::SLOT_W'(1));

    // rotate from cursor, first due slot wins
    always_comb begin
        found      = 1'b0;
        adv_cursor = (r_cursor == rrsg_pkg::CUR_W'(rrsg_pkg::SLOTS - 1)) ?
                     '0 : r_cursor + rrsg_pkg::CUR_W'(1);
        idx        = '0;
        for (int i = 0; i < rrsg_pkg::SLOTS; i++) begin
            idx = {1'b0, r_cursor} + IDX_W'(i);
            if (idx >= IDX_W'(rrsg_pkg::SLOTS)) begin
                idx = idx - IDX_W'(rrsg_pkg::SLOTS);
            end
            if (!found && i_item.due_mask[idx[rrsg_pkg::CUR_W-1:0]]) begin
                found      = 1'b1;
                adv_cursor = idx[rrsg_pkg::CUR_W-1:0];
            end
        end
    end

    always_comb begin
        n_grant_flags         = r_grant_flags;
        n_cursor              = r_cursor;
        n_cool_until          = r_cool_until;
        n_fail_count          = r_fail_count;
        o_res.granted         = 1'b0;
        o_res.refusal         = rrsg_pkg::REF_NO_REQ;
        o_res.restart_request = 1'b0;
        unique case (i_item.opcode)
            rrsg_pkg::OP_START: begin
                priority if (held) begin
                    o_res.granted = 1'b1;
                    o_res.refusal = rrsg_pkg::REF_GRANTED;
                end else if (busy) begin
                    o_res.refusal = rrsg_pkg::REF_BUSY;
                end else if (rrsg_pkg::CUR_W'(i_item.slot) != r_cursor || !slot_ok) begin
                    o_res.refusal = rrsg_pkg::REF_NOT_TURN;
                end else if (low_heap) begin
                    o_res.refusal = rrsg_pkg::REF_LOW_HEAP;
                end else if (cooling) begin
                    o_res.refusal = rrsg_pkg::REF_COOLDOWN;
                end else begin
                    n_grant_flags = r_grant_flags | slot_bit;
                    o_res.granted = 1'b1;
                    o_res.refusal = rrsg_pkg::REF_GRANTED;
                end
            end
            rrsg_pkg::OP_DONE: begin
                if (slot_ok) begin
                    n_grant_flags = r_grant_flags & ~slot_bit;
                    n_cursor      = done_cursor;
                    if (held) begin
                        n_cool_until = i_item.now_ms +
                                       rrsg_pkg::TIME_W'(i_cfg.cooldown_length);
                    end
                end
            end
            rrsg_pkg::OP_ADVANCE: begin
                if (!busy && !cooling && !low_heap) begin
                    n_cursor = adv_cursor;
                end
            end
            rrsg_pkg::OP_SUCCESS: begin
                n_fail_count = '0;
            end
            rrsg_pkg::OP_FAILURE: begin
                n_fail_count          = fail_inc;
                o_res.restart_request = fail_inc >= i_cfg.fail_limit;
            end
            default: begin
                o_res.refusal = rrsg_pkg::REF_NO_REQ;
            end
        endcase
        o_res.cursor   = n_cursor;
        o_res.busy_res = n_grant_flags != '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grant_flags <= '0;
            r_cursor      <= '0;
            r_cool_until  <= '0;
            r_fail_count  <= '0;
        end else if (i_step) begin
            r_grant_flags <= n_grant_flags;
            r_cursor      <= n_cursor;
            r_cool_until  <= n_cool_until;
            r_fail_count  <= n_fail_count;
        end
    end

`ifndef SYNTHESIS
    a_single_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_grant_flags))
        else $error("more than one slot holds a grant");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor < rrsg_pkg::CUR_W'(rrsg_pkg::SLOTS))
        else $error("turn cursor out of slot range");

    a_done_releases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.opcode == rrsg_pkg::OP_DONE && slot_ok)
        |=> ((r_grant_flags & $past(slot_bit)) == '0))
        else $error("done transaction left its grant set");

    a_fail_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.opcode == rrsg_pkg::OP_FAILURE &&
         r_fail_count == rrsg_pkg::FAIL_MAX)
        |=> (r_fail_count == rrsg_pkg::FAIL_MAX))
        else $error("failure counter wrapped");
`endif

endmodule

[src/round_robin_single_grant_scheduler_core.sv]
// ----------------------------------------------------------------------------
// round_robin_single_grant_scheduler_core: round-robin single-grant scheduler
// Datapath: an accepted transaction is registered in r_s1, then its result is registered in r_out.
// Throughput: one transaction per cycle while o_out.ready does not stall; state updates in one combinational pass.
// Reset (sync, active low): grants, cursor, cooldown, fail count cleared; config to defaults.
// ----------------------------------------------------------------------------
module round_robin_single_grant_scheduler_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    rrsg_in_if.sink                         i_in,
    rrsg_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [rrsg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rrsg_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    rrsg_pkg::t_cfg     cfg;
    rrsg_pkg::t_result  res;
    logic               s1_fire;
    logic               in_fire;

    logic               r_s1_valid;
    rrsg_pkg::t_item    r_s1;
    logic               r_out_valid;
    rrsg_pkg::t_result  r_out;

    assign s1_fire   = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_fire;
    assign in_fire   = i_in.valid && i_in.ready;

    rrsg_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    rrsg_sched u_sched (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (s1_fire),
        .i_item  (r_s1),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1.opcode     <= i_in.opcode;
            r_s1.slot       <= i_in.slot;
            r_s1.due_mask   <= i_in.due_mask;
            r_s1.free_block <= i_in.free_block;
            r_s1.now_ms     <= i_in.now_ms;
        end
        if (s1_fire) begin
            r_out <= res;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.granted         = r_out.granted;
    assign o_out.refusal         = r_out.refusal;
    assign o_out.cursor          = r_out.cursor;
    assign o_out.busy_res        = r_out.busy_res;
    assign o_out.restart_request = r_out.restart_request;

endmodule
